[design/lsrc_pkg.sv]
// Package with shared constants and types of the line segment clipper.
package lsrc_pkg;

	localparam int CoordBits = 24;
	localparam int FracBits  = 20;

	// Register indexes of the configuration port.
	localparam logic [1:0] RegXMin = 2'd0;
	localparam logic [1:0] RegXMax = 2'd1;
	localparam logic [1:0] RegYMin = 2'd2;
	localparam logic [1:0] RegYMax = 2'd3;

	// Ratio class of one edge, as seen by the u1/u2 tracking.
	typedef enum logic [1:0] {
		RatZero,
		RatNeg,
		RatOver,
		RatFrac
	} ratio_kind_t;

endpackage

[design/lsrc_if.sv]
// Valid/ready channel interfaces of the line segment clipper.
interface lsrc_seg_if #(parameter int CoordBits = lsrc_pkg::CoordBits) ();
	logic                        valid;
	logic                        ready;
	logic signed [CoordBits-1:0] start_x;
	logic signed [CoordBits-1:0] start_y;
	logic signed [CoordBits-1:0] end_x;
	logic signed [CoordBits-1:0] end_y;
	modport source (output valid, start_x, start_y, end_x, end_y, input ready);
	modport sink (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface lsrc_res_if #(parameter int CoordBits = lsrc_pkg::CoordBits) ();
	logic                        valid;
	logic                        ready;
	logic                        visible;
	logic signed [CoordBits-1:0] clipped_start_x;
	logic signed [CoordBits-1:0] clipped_start_y;
	logic signed [CoordBits-1:0] clipped_end_x;
	logic signed [CoordBits-1:0] clipped_end_y;
	modport source (output valid, visible, clipped_start_x, clipped_start_y,
		clipped_end_x, clipped_end_y, input ready);
	modport sink (input valid, visible, clipped_start_x, clipped_start_y,
		clipped_end_x, clipped_end_y, output ready);
endinterface

interface lsrc_cfg_if #(parameter int CoordBits = lsrc_pkg::CoordBits) ();
	logic                 valid;
	logic                 ready;
	logic [1:0]           index;
	logic [CoordBits-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[design/lsrc_div_stage.sv]
// One restoring division step of a pipelined fraction divider.
module lsrc_div_stage #(
	parameter int W = lsrc_pkg::CoordBits + 1,
	parameter int QW = lsrc_pkg::FracBits
) (
	input  logic          clk,
	input  logic          en,
	input  logic [W-1:0]  rem_in,
	input  logic [W-1:0]  den_in,
	input  logic [QW-1:0] quo_in,
	output logic [W-1:0]  rem_out,
	output logic [W-1:0]  den_out,
	output logic [QW-1:0] quo_out
);
	logic [W:0] shifted;
	logic       take;

	// Remainder never exceeds the divisor, so one extra bit holds the shift.
	assign shifted = {rem_in, 1'b0};
	assign take    = shifted >= {1'b0, den_in};

	always_ff @(posedge clk) begin
		if (en) begin
			rem_out <= take ? W'(shifted - {1'b0, den_in}) : W'(shifted);
			den_out <= den_in;
			quo_out <= {quo_in[QW-2:0], take};
		end
	end
endmodule

[design/lsrc_edge_div.sv]
// Pipelined ratio unit: divides q/p of one edge over FracBits stages and maps its class to u.
module lsrc_edge_div #(
	parameter int CoordBits = lsrc_pkg::CoordBits,
	parameter int FracBits  = lsrc_pkg::FracBits
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic [CoordBits:0]   aq,
	input  logic [CoordBits:0]   ap,
	input  lsrc_pkg::ratio_kind_t kind,
	output lsrc_pkg::ratio_kind_t kind_out,
	output logic [FracBits:0]    u_out
);
	localparam int W = CoordBits + 1;

	logic [W-1:0]        rem [0:FracBits];
	logic [W-1:0]        den [0:FracBits];
	logic [FracBits-1:0] quo [0:FracBits];
	lsrc_pkg::ratio_kind_t kd [0:FracBits];

	assign rem[0] = aq;
	assign den[0] = ap;
	assign quo[0] = '0;
	assign kd[0]  = kind;

	for (genvar i = 0; i < FracBits; i++) begin : g_st
		lsrc_div_stage #(.W(W), .QW(FracBits)) u_st (
			.clk(clk), .en(en),
			.rem_in(rem[i]), .den_in(den[i]), .quo_in(quo[i]),
			.rem_out(rem[i+1]), .den_out(den[i+1]), .quo_out(quo[i+1])
		);
		always_ff @(posedge clk) begin
			if (en) kd[i+1] <= kd[i];
		end
	end

	assign kind_out = kd[FracBits];

	// Equal magnitudes give exactly one; only then does the remainder stay
	// equal to the divisor through every step.
	always_comb begin
		unique case (kd[FracBits])
			lsrc_pkg::RatZero: u_out = '0;
			lsrc_pkg::RatNeg:  u_out = '0;
			lsrc_pkg::RatOver: u_out = {1'b1, {(FracBits-1){1'b0}}, 1'b1};
			lsrc_pkg::RatFrac: u_out = (rem[FracBits] == den[FracBits])
				? {1'b1, {FracBits{1'b0}}}
				: {1'b0, quo[FracBits]};
			default:           u_out = '0;
		endcase
	end
endmodule

[design/lsrc_mul_stage.sv]
// Interpolation of one coordinate: start plus truncated u times delta, two stages.
module lsrc_mul_stage #(
	parameter int CoordBits = lsrc_pkg::CoordBits,
	parameter int FracBits  = lsrc_pkg::FracBits
) (
	input  logic                        clk,
	input  logic                        en,
	input  logic signed [CoordBits-1:0] start,
	input  logic signed [CoordBits:0]   delta,
	input  logic [FracBits:0]           u,
	output logic signed [CoordBits-1:0] res
);
	localparam int PW = CoordBits + FracBits + 2;

	logic [CoordBits:0]          mag;
	logic [PW-1:0]               prod_s1;
	logic                        neg_s1;
	logic signed [CoordBits-1:0] start_s1;
	logic [CoordBits:0]          off;

	assign mag = delta[CoordBits] ? (CoordBits+1)'(-delta) : delta;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1  <= PW'(mag) * PW'(u);
			neg_s1   <= delta[CoordBits];
			start_s1 <= start;
		end
	end

	assign off = prod_s1[FracBits +: (CoordBits+1)];

	always_ff @(posedge clk) begin
		if (en) begin
			res <= neg_s1 ? CoordBits'(start_s1 - off) : CoordBits'(start_s1 + off);
		end
	end
endmodule

[design/line_segment_rect_clipper_core.sv]
// Top level of the Liang-Barsky line segment clipper.
//
//   channel  dir  handshake     payload
//   seg      in   valid/ready   start_x, start_y, end_x, end_y
//   res      out  valid/ready   visible, clipped start and end points
//   cfg      in   valid/ready   index, data (clip rectangle edges)
//
// One segment enters per clock while the pipeline is enabled, and the 20-step
// divider pipeline sets the depth. All stages advance together on a global
// enable; an output register parts the pipeline from the sink, so the block
// keeps accepting while the output is empty or being taken. Reset clears the
// valid bits and sets the rectangle to the widest extent.
module line_segment_rect_clipper_core #(
	parameter int CoordBits = lsrc_pkg::CoordBits,
	parameter int FracBits  = lsrc_pkg::FracBits
) (
	input logic clk,
	input logic arst_n,
	lsrc_seg_if.sink   seg,
	lsrc_res_if.source res,
	lsrc_cfg_if.sink   cfg
);
	localparam int Depth = FracBits + 5;
	localparam int UW    = FracBits + 1;

	logic signed [CoordBits-1:0] xmin_q, xmax_q, ymin_q, ymax_q;

	// Configuration is always taken.
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xmin_q <= {1'b1, {(CoordBits-1){1'b0}}};
			xmax_q <= {1'b0, {(CoordBits-1){1'b1}}};
			ymin_q <= {1'b1, {(CoordBits-1){1'b0}}};
			ymax_q <= {1'b0, {(CoordBits-1){1'b1}}};
		end else if (cfg.valid) begin
			unique case (cfg.index)
				lsrc_pkg::RegXMin: xmin_q <= cfg.data;
				lsrc_pkg::RegXMax: xmax_q <= cfg.data;
				lsrc_pkg::RegYMin: ymin_q <= cfg.data;
				lsrc_pkg::RegYMax: ymax_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// The whole pipeline moves when the output register is free or drained.
	logic en;
	logic [Depth-1:0] vld_q;
	assign en        = !res.valid || res.ready;
	assign seg.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[Depth-2:0], seg.valid};
	end

	// Stage 1: register the inputs, deltas and q values.
	logic signed [CoordBits-1:0] sx_s1, sy_s1;
	logic signed [CoordBits:0]   dx_s1, dy_s1;
	logic signed [CoordBits:0]   q_s1 [4];

	always_ff @(posedge clk) begin
		if (en) begin
			sx_s1   <= seg.start_x;
			sy_s1   <= seg.start_y;
			dx_s1   <= (CoordBits+1)'(seg.end_x) - (CoordBits+1)'(seg.start_x);
			dy_s1   <= (CoordBits+1)'(seg.end_y) - (CoordBits+1)'(seg.start_y);
			q_s1[0] <= (CoordBits+1)'(seg.start_x) - (CoordBits+1)'(xmin_q);
			q_s1[1] <= (CoordBits+1)'(xmax_q) - (CoordBits+1)'(seg.start_x);
			q_s1[2] <= (CoordBits+1)'(seg.start_y) - (CoordBits+1)'(ymin_q);
			q_s1[3] <= (CoordBits+1)'(ymax_q) - (CoordBits+1)'(seg.start_y);
		end
	end

	// Stage 2 input: classify each edge and form magnitudes.
	logic signed [CoordBits:0] p_c [4];
	logic [CoordBits:0] aq_c [4], ap_c [4];
	lsrc_pkg::ratio_kind_t kind_c [4];
	logic [3:0] par_rej_c, entry_c;

	assign p_c[0] = -dx_s1;
	assign p_c[1] = dx_s1;
	assign p_c[2] = -dy_s1;
	assign p_c[3] = dy_s1;

	// Deltas and q fit in CoordBits+1 signed bits; magnitudes fit unsigned.
	for (genvar e = 0; e < 4; e++) begin : g_cls
		assign aq_c[e] = q_s1[e][CoordBits] ? (CoordBits+1)'(-q_s1[e]) : q_s1[e];
		assign ap_c[e] = p_c[e][CoordBits] ? (CoordBits+1)'(-p_c[e]) : p_c[e];
		assign par_rej_c[e] = (p_c[e] == '0) && q_s1[e][CoordBits];
		assign entry_c[e]   = p_c[e][CoordBits];
		always_comb begin
			priority if (p_c[e] == '0 || q_s1[e] == '0) kind_c[e] = lsrc_pkg::RatZero;
			else if (q_s1[e][CoordBits] != p_c[e][CoordBits]) kind_c[e] = lsrc_pkg::RatNeg;
			else if (aq_c[e] > ap_c[e]) kind_c[e] = lsrc_pkg::RatOver;
			else kind_c[e] = lsrc_pkg::RatFrac;
		end
	end

	// Side data travelling alongside the divider. The edge flags are needed
	// when the ratios come out, the coordinates one stage later.
	localparam int SL = FracBits + 1;
	localparam int SD = FracBits + 2;
	logic signed [CoordBits-1:0] sx_d [SD], sy_d [SD];
	logic signed [CoordBits:0]   dx_d [SD], dy_d [SD];
	logic [3:0] rej_d [SL], ent_d [SL], nz_d [SL];

	always_ff @(posedge clk) begin
		if (en) begin
			sx_d[0] <= sx_s1; sy_d[0] <= sy_s1;
			dx_d[0] <= dx_s1; dy_d[0] <= dy_s1;
			rej_d[0] <= par_rej_c; ent_d[0] <= entry_c;
			for (int e = 0; e < 4; e++) nz_d[0][e] <= p_c[e] != '0;
			for (int k = 1; k < SD; k++) begin
				sx_d[k] <= sx_d[k-1]; sy_d[k] <= sy_d[k-1];
				dx_d[k] <= dx_d[k-1]; dy_d[k] <= dy_d[k-1];
			end
			for (int k = 1; k < SL; k++) begin
				rej_d[k] <= rej_d[k-1]; ent_d[k] <= ent_d[k-1]; nz_d[k] <= nz_d[k-1];
			end
		end
	end

	// Divider inputs registered as stage 2.
	logic [CoordBits:0] aq_s2 [4], ap_s2 [4];
	lsrc_pkg::ratio_kind_t kind_s2 [4];
	lsrc_pkg::ratio_kind_t kind_o [4];
	logic [UW-1:0] u_o [4];

	for (genvar e = 0; e < 4; e++) begin : g_div
		always_ff @(posedge clk) begin
			if (en) begin
				aq_s2[e]   <= aq_c[e];
				ap_s2[e]   <= ap_c[e];
				kind_s2[e] <= kind_c[e];
			end
		end
		lsrc_edge_div #(.CoordBits(CoordBits), .FracBits(FracBits)) u_div (
			.clk(clk), .en(en), .aq(aq_s2[e]), .ap(ap_s2[e]), .kind(kind_s2[e]),
			.kind_out(kind_o[e]), .u_out(u_o[e])
		);
	end

	// u1/u2 tracking; a negative exit ratio, a parallel edge outside or u1 above u2 forces rejection.
	logic [UW-1:0] u1_c, u2_c;
	logic          ok_c;
	always_comb begin
		u1_c = '0;
		u2_c = {1'b1, {FracBits{1'b0}}};
		ok_c = 1'b1;
		for (int e = 0; e < 4; e++) begin
			if (rej_d[SL-1][e]) ok_c = 1'b0;
			if (nz_d[SL-1][e]) begin
				if (ent_d[SL-1][e]) begin
					if (kind_o[e] != lsrc_pkg::RatNeg && u_o[e] > u1_c) u1_c = u_o[e];
				end else if (kind_o[e] == lsrc_pkg::RatNeg) begin
					ok_c = 1'b0;
				end else if (u_o[e] < u2_c) begin
					u2_c = u_o[e];
				end
			end
		end
		if (u1_c > u2_c) ok_c = 1'b0;
	end

	logic [UW-1:0] u1_s3, u2_s3;
	logic          ok_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			u1_s3 <= u1_c;
			u2_s3 <= u2_c;
			ok_s3 <= ok_c;
		end
	end

	// Two interpolation stages per coordinate.
	logic signed [CoordBits-1:0] csx, csy, cex, cey;
	logic ok_s4, ok_s5;
	lsrc_mul_stage #(.CoordBits(CoordBits), .FracBits(FracBits)) u_msx (
		.clk(clk), .en(en), .start(sx_d[SD-1]), .delta(dx_d[SD-1]), .u(u1_s3), .res(csx));
	lsrc_mul_stage #(.CoordBits(CoordBits), .FracBits(FracBits)) u_msy (
		.clk(clk), .en(en), .start(sy_d[SD-1]), .delta(dy_d[SD-1]), .u(u1_s3), .res(csy));
	lsrc_mul_stage #(.CoordBits(CoordBits), .FracBits(FracBits)) u_mex (
		.clk(clk), .en(en), .start(sx_d[SD-1]), .delta(dx_d[SD-1]), .u(u2_s3), .res(cex));
	lsrc_mul_stage #(.CoordBits(CoordBits), .FracBits(FracBits)) u_mey (
		.clk(clk), .en(en), .start(sy_d[SD-1]), .delta(dy_d[SD-1]), .u(u2_s3), .res(cey));

	// The coordinate line is one stage longer than the divider, which matches
	// the stage-3 u registers, so the multipliers see aligned operands.
	always_ff @(posedge clk) begin
		if (en) begin
			ok_s4 <= ok_s3;
			ok_s5 <= ok_s4;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) res.valid <= 1'b0;
		else if (en) res.valid <= vld_q[Depth-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res.visible         <= ok_s5;
			res.clipped_start_x <= ok_s5 ? csx : '0;
			res.clipped_start_y <= ok_s5 ? csy : '0;
			res.clipped_end_x   <= ok_s5 ? cex : '0;
			res.clipped_end_y   <= ok_s5 ? cey : '0;
		end
	end
endmodule
